// ----- src/pal_pkg.sv -----
// Shared types and constants for the positional array list unit.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 8;
  localparam int CAPACITY_DEF = 128;
  // Number of cell taps gathered by one register of the first OR level.
  localparam int GROUP        = 8;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_READ   = 2'd3
  } pal_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } pal_status_e;

  typedef struct packed {
    pal_kind_e                 kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } pal_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    pal_status_e               status;
    logic [COUNT_W-1:0]        moved;
    logic [COUNT_W-1:0]        count_after;
  } pal_out_t;

  // Command broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      tap;
    logic [POS_W-1:0]          pos;
    logic [DATA_W-1:0]         value;
  } pal_cmd_t;

endpackage

`default_nettype wire

// ----- src/positional_array_list_unit.sv -----
// Top level of the positional array list unit.
`timescale 1ns / 1ps
`default_nettype none

// The list lives in a row of CAPACITY cells; an insert or delete shifts every
// later entry by one place in the cycle the item is accepted, and read,
// append and delete need no further work on the cells. One item is handled at
// a time: accepting an item, gathering the addressed entry through two
// registered OR levels (GROUP cell taps per first-level register, then all
// groups), and handing over the result run through the states S_IDLE, S_TAP,
// S_GRP and S_OUT, and the block takes no new item until its result is taken.
// Entries hold no reset value; only entries below the count are ever returned.
module positional_array_list_unit #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pal_pkg::pal_in_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pal_pkg::pal_out_t      out_o
);
  import pal_pkg::*;

  localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;
  localparam logic [COUNT_W-1:0] CAP_L = COUNT_W'(CAPACITY);
  localparam logic [COUNT_W-1:0] ONE_L = COUNT_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAP  = 2'd1;
  localparam logic [1:0] S_GRP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               accept;
  pal_cmd_t           cmd;
  pal_status_e        status_d, status_q;
  logic [COUNT_W-1:0] moved_d, moved_q;
  logic [DATA_W-1:0]  value_q, value_d;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [CAPACITY];
  logic [DATA_W-1:0] grp       [NGRP];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd       = '0;
    cmd.pos   = in_i.position;
    cmd.value = in_i.value;
    status_d  = ST_OK;
    moved_d   = '0;
    count_d   = count_q;
    unique case (in_i.kind)
      KIND_INSERT: begin
        if (in_i.position > count_q) begin
          status_d = ST_BAD_POS;
        end else if (count_q >= CAP_L) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = accept;
          moved_d = count_q - in_i.position;
          count_d = count_q + ONE_L;
        end
      end
      KIND_APPEND: begin
        if (count_q >= CAP_L) begin
          status_d = ST_FULL;
        end else begin
          // Loading the cell at the current count shifts nothing held.
          cmd.ins = accept;
          cmd.pos = count_q;
          count_d = count_q + ONE_L;
        end
      end
      KIND_DELETE: begin
        if (in_i.position >= count_q) begin
          status_d = ST_BAD_POS;
          cmd.tap  = accept;
          cmd.pos  = CAP_L;
        end else begin
          cmd.del = accept;
          cmd.tap = accept;
          moved_d = count_q - ONE_L - in_i.position;
          count_d = count_q - ONE_L;
        end
      end
      KIND_READ: begin
        cmd.tap = accept;
        if (in_i.position >= count_q) begin
          status_d = ST_BAD_POS;
          cmd.pos  = CAP_L;
        end
      end
      default: begin
        status_d = ST_BAD_POS;
      end
    endcase
    // Every accepted item refreshes the taps so stale entries never leak.
    if (accept) begin
      cmd.tap = 1'b1;
      if (in_i.kind == KIND_INSERT || in_i.kind == KIND_APPEND) begin
        cmd.pos = cmd.ins ? cmd.pos : CAP_L;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end

    pal_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .tap_o  (cell_tap[i])
    );
  end

  pal_gather #(
    .CAPACITY(CAPACITY),
    .NGRP    (NGRP)
  ) u_gather (
    .clk_i (clk_i),
    .taps_i(cell_tap),
    .grp_o (grp)
  );

  // An insert or append leaves a tap at the cell it loads; it is masked off here.
  logic is_read_q;

  always_comb begin
    value_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      value_d = value_d | grp[g];
    end
    if (!is_read_q) begin
      value_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_TAP;
      S_TAP:  state_d = S_GRP;
      S_GRP:  state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      moved_q   <= moved_d;
      is_read_q <= (status_d == ST_OK) &&
                   (in_i.kind == KIND_DELETE || in_i.kind == KIND_READ);
    end
    if (state_q == S_GRP) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o        = (state_q == S_OUT);
  assign out_o.result_value = value_q;
  assign out_o.status       = status_q;
  assign out_o.moved        = moved_q;
  assign out_o.count_after  = count_q;

endmodule

`default_nettype wire

// ----- src/pal_cell.sv -----
// One list cell: holds an entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
  parameter int IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire pal_pkg::pal_cmd_t           cmd_i,
  input  wire logic [pal_pkg::DATA_W-1:0]  left_i,
  input  wire logic [pal_pkg::DATA_W-1:0]  right_i,
  output logic      [pal_pkg::DATA_W-1:0]  data_o,
  output logic      [pal_pkg::DATA_W-1:0]  tap_o
);
  import pal_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [DATA_W-1:0] data_q, data_d;
  logic [DATA_W-1:0] tap_q, tap_d;
  logic              hit;

  assign hit = (cmd_i.pos == MY_POS);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (hit) begin
        data_d = cmd_i.value;
      end else if (MY_POS > cmd_i.pos) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (MY_POS >= cmd_i.pos) begin
        data_d = right_i;
      end
    end
  end

  // The tap keeps the entry as it was before this item's shift.
  always_comb begin
    tap_d = tap_q;
    if (cmd_i.ins || cmd_i.del || cmd_i.tap) begin
      tap_d = (cmd_i.tap && hit) ? data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign data_o = data_q;
  assign tap_o  = tap_q;

endmodule

`default_nettype wire

// ----- src/pal_gather.sv -----
// First level of the registered OR tree that collects the tapped entry.
`timescale 1ns / 1ps
`default_nettype none

module pal_gather #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int NGRP     = (CAPACITY + pal_pkg::GROUP - 1) / pal_pkg::GROUP
) (
  input  wire logic                        clk_i,
  input  wire logic [pal_pkg::DATA_W-1:0]  taps_i [CAPACITY],
  output logic      [pal_pkg::DATA_W-1:0]  grp_o  [NGRP]
);
  import pal_pkg::*;

  logic [DATA_W-1:0] grp_q [NGRP];
  logic [DATA_W-1:0] grp_d [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | taps_i[g * GROUP + j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d[g];
    end

    assign grp_o[g] = grp_q[g];
  end

endmodule

`default_nettype wire

// ----- src/pal_checker.sv -----
// Port-level checks for the positional array list unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pal_checker #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire pal_pkg::pal_out_t out_o
);
  import pal_pkg::*;

  // Only one item is in the block at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result waits");

  // A failed request leaves no value and moves nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_OK |-> out_o.moved == '0 &&
      out_o.result_value == '0)
    else $error("failed request reports data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.count_after <= COUNT_W'(CAPACITY) &&
      out_o.moved < COUNT_W'(CAPACITY))
    else $error("count or moved beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind positional_array_list_unit pal_checker #(.CAPACITY(CAPACITY)) u_pal_checker (.*);

`default_nettype wire

// ----- dv/positional_array_list_unit_tb.sv -----
// Self-checking testbench for the positional array list unit.
`timescale 1ns / 1ps

module positional_array_list_unit_tb;
  import pal_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_MAX   = 40;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pal_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pal_out_t out_item;

  positional_array_list_unit #(
    .CAPACITY(CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted list contents, updated as each item is accepted.
  logic signed [DATA_W-1:0] list_mem [CAP];
  int                       list_count = 0;

  pal_in_t  request_queue[$];
  pal_out_t replies_due[$];

  // Bookkeeping for stimulus generation: the count the list will have.
  int gen_count = 0;

  bit in_took  = 1'b0;
  bit out_took = 1'b0;
  bit valid_next;
  bit ready_next;
  bit busy;

  int send_gap   = 0;
  bit send_calm  = 1'b0;
  int recv_wait  = 0;
  bit recv_calm  = 1'b0;
  int hold_left  = 0;
  int holds_done = 0;

  int results_seen   = 0;
  int mismatch_total = 0;
  int idle_cycles    = 0;
  int peak_count     = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  function automatic pal_out_t apply_list_op(pal_in_t req);
    pal_out_t res;
    int       pos;
    int       i;
    res = '0;
    pos = int'(req.position);
    case (req.kind)
      KIND_INSERT: begin
        // A position past the end is rejected before fullness is considered.
        if (pos > list_count) begin
          res.status = ST_BAD_POS;
        end else if (list_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = req.value;
          res.moved = COUNT_W'(list_count - pos);
          list_count++;
        end
      end
      KIND_APPEND: begin
        if (list_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_count] = req.value;
          list_count++;
        end
      end
      KIND_DELETE: begin
        if (pos >= list_count) begin
          res.status = ST_BAD_POS;
        end else begin
          res.result_value = list_mem[pos];
          for (i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          res.moved = COUNT_W'(list_count - 1 - pos);
          list_count--;
        end
      end
      default: begin
        if (pos >= list_count) res.status = ST_BAD_POS;
        else res.result_value = list_mem[pos];
      end
    endcase
    res.count_after = COUNT_W'(list_count);
    return res;
  endfunction

  task automatic queue_request(pal_kind_e kind, int pos, logic [DATA_W-1:0] value);
    pal_in_t req;
    req.kind     = kind;
    req.position = POS_W'(pos);
    req.value    = value;
    request_queue.push_back(req);
    case (kind)
      KIND_INSERT: if (pos <= gen_count && gen_count < CAP) gen_count++;
      KIND_APPEND: if (gen_count < CAP) gen_count++;
      KIND_DELETE: if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic pal_kind_e pick_kind(bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      return roll < 40 ? KIND_INSERT : roll < 75 ? KIND_APPEND :
             roll < 88 ? KIND_DELETE : KIND_READ;
    end
    return roll < 55 ? KIND_DELETE : roll < 65 ? KIND_INSERT :
           roll < 72 ? KIND_APPEND : KIND_READ;
  endfunction

  // Mostly legal positions, with the edges and some out-of-range noise mixed in.
  function automatic int pick_position(pal_kind_e kind);
    int top;
    top = (kind == KIND_INSERT) ? gen_count : gen_count - 1;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 255);
      1: return (top < 0) ? 0 : top;
      2: return 0;
      default: return (top < 0) ? 0 : $urandom_range(0, top);
    endcase
  endfunction

  task automatic check_field(string field, logic [DATA_W-1:0] want,
                             logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, $signed(want), $signed(got));
    end
  endtask

  // Driver: offers the next item at the falling edge once the gap has run out.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      valid_next = in_valid;
      if (in_took) valid_next = 1'b0;
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() > 0) begin
          in_item <= request_queue.pop_front();
          valid_next = 1'b1;
          if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 7);
        end
      end
      in_valid <= valid_next;
    end
  end

  // Receiver: stalls a random number of cycles per item, and now and then
  // holds off long enough for the block to back up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        if (results_seen % 600 == 300) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (recv_wait > 0 && out_valid) recv_wait--;
        ready_next = (recv_wait == 0);
      end
      out_ready <= ready_next;
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    in_took  = in_valid && in_ready;
    out_took = out_valid && out_ready;
    if (in_took) replies_due.push_back(apply_list_op(in_item));
    if (out_took) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= REPORT_MAX)
          $display("%0t ns: unexpected result, expected none, actual %h",
                   $time, out_item);
      end else begin
        check_field("result_value", replies_due[0].result_value, out_item.result_value);
        check_field("status", DATA_W'(replies_due[0].status), DATA_W'(out_item.status));
        check_field("moved", DATA_W'(replies_due[0].moved), DATA_W'(out_item.moved));
        check_field("count_after", DATA_W'(replies_due[0].count_after),
                    DATA_W'(out_item.count_after));
        void'(replies_due.pop_front());
        status_seen[out_item.status]++;
        if (int'(out_item.count_after) > peak_count) begin
          peak_count = int'(out_item.count_after);
        end
      end
    end
    busy = request_queue.size() > 0 || in_valid || replies_due.size() > 0;
    if (in_took || out_took || !busy) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without progress.", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit               growing;
    pal_kind_e        kind;
    logic [DATA_W-1:0] val;

    // Directed opening: empty-list rejections, inserts at front, middle and
    // end, reads across the list and deletes from middle, end and front.
    queue_request(KIND_READ, 0, '0);
    queue_request(KIND_DELETE, 0, '0);
    queue_request(KIND_INSERT, 1, 32'h0000_1111);
    queue_request(KIND_INSERT, 255, 32'hffff_ffff);
    queue_request(KIND_INSERT, 0, 32'h7fff_ffff);
    queue_request(KIND_APPEND, 255, 32'h8000_0000);
    queue_request(KIND_INSERT, 1, 32'hffff_ffff);
    queue_request(KIND_INSERT, 3, 32'h0000_0000);
    queue_request(KIND_INSERT, 0, 32'h5a5a_a5a5);
    for (int n = 0; n < 6; n++) queue_request(KIND_READ, n, 32'hffff_ffff);
    queue_request(KIND_READ, 255, '0);
    queue_request(KIND_DELETE, 255, '0);
    queue_request(KIND_DELETE, 2, '0);
    queue_request(KIND_DELETE, 3, '0);
    queue_request(KIND_DELETE, 0, '0);
    queue_request(KIND_APPEND, 0, 32'h0000_0001);

    // Random part: alternate growing and shrinking phases so the list is
    // driven to full and back to empty several times.
    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (growing && gen_count == CAP && $urandom_range(0, 5) == 0) growing = 1'b0;
      else if (!growing && gen_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      else if ($urandom_range(0, 299) == 0) growing = !growing;
      kind = pick_kind(growing);
      case ($urandom_range(0, 15))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        default: val = $urandom;
      endcase
      queue_request(kind, pick_position(kind), val);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || in_valid || replies_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d results: %0d ok, %0d bad position, %0d list full.",
             results_seen, status_seen[ST_OK], status_seen[ST_BAD_POS],
             status_seen[ST_FULL]);
    $display("List peaked at %0d of %0d entries; output held off %0d times.",
             peak_count, CAP, holds_done);
    if (mismatch_total == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
